// ----- sv/ocvsoc_pkg.sv -----
// Shared constants and types for the OCV state-of-charge lookup.
// Holds the breakpoint tables, segment reciprocals and divider sizing.
// No dependencies.
package ocvsoc_pkg;

	localparam int PACK_W   = 16;
	localparam int CELL_W   = 8;
	localparam int SOC_W    = 10;
	localparam int NUM_W    = 24;
	localparam int DIV_BITS = 4;
	localparam int DIV_STAGES = NUM_W / DIV_BITS;
	localparam int MV_W     = 13;
	localparam int SEG_W    = 4;
	localparam int DIFF_W   = 7;
	localparam int SCALED_W = 14;
	localparam int RECIP_W  = 18;
	localparam int RECIP_SHIFT = 22;
	localparam int FRAC_W   = 7;
	localparam int PROD_W   = 32;
	localparam int OCV_POINTS = 11;
	localparam int SEGMENTS = OCV_POINTS - 1;

	localparam logic [CELL_W-1:0] CELL_COUNT_RESET = 8'd144;
	localparam logic [SOC_W-1:0]  SOC_FULL  = 10'd1000;
	localparam logic [SOC_W-1:0]  SOC_EMPTY = 10'd0;

	localparam logic [MV_W-1:0] OCV_MV [OCV_POINTS] = '{
		13'd3600, 13'd3684, 13'd3724, 13'd3762, 13'd3780, 13'd3798,
		13'd3836, 13'd3905, 13'd3960, 13'd4033, 13'd4150
	};

	localparam logic [SOC_W-1:0] OCV_SOC [SEGMENTS] = '{
		10'd0, 10'd100, 10'd200, 10'd300, 10'd400,
		10'd500, 10'd600, 10'd700, 10'd800, 10'd900
	};

	// ceil(2^22 / segment width)
	localparam logic [RECIP_W-1:0] SEG_RECIP [SEGMENTS] = '{
		18'd49933, 18'd104858, 18'd110377, 18'd233017, 18'd233017,
		18'd110377, 18'd60788, 18'd76261, 18'd57457, 18'd35849
	};

	typedef struct packed {
		logic [CELL_W-1:0] rem;
		logic [NUM_W-1:0]  num;
		logic [CELL_W-1:0] dvs;
	} div_word_t;

endpackage

// ----- sv/ocvsoc_div_stage.sv -----
// One stage of the pipelined restoring divider: four quotient bits per stage.
// Quotient bits shift into the low end of num as dividend bits leave the top.
// Depends on ocvsoc_pkg.
module ocvsoc_div_stage import ocvsoc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_word_t in_word,
	output logic      out_valid,
	output div_word_t out_word
);

	logic [CELL_W:0]   trial;
	logic [CELL_W-1:0] rem_c;
	logic [NUM_W-1:0]  num_c;

	always_comb begin
		rem_c = in_word.rem;
		num_c = in_word.num;
		trial = '0;
		for (int k = 0; k < DIV_BITS; k++) begin
			trial = {rem_c, num_c[NUM_W-1]};
			num_c = {num_c[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, in_word.dvs}) begin
				trial    = trial - {1'b0, in_word.dvs};
				num_c[0] = 1'b1;
			end
			rem_c = trial[CELL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_word.rem <= rem_c;
		out_word.num <= num_c;
		out_word.dvs <= in_word.dvs;
	end

endmodule

// ----- sv/ocvsoc_interp.sv -----
// Piecewise-linear interpolation over the OCV table, four register stages.
// Segment search, scale by 100, reciprocal multiply, offset add and clamp.
// Depends on ocvsoc_pkg.
module ocvsoc_interp import ocvsoc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] avg_mv,
	output logic             out_valid,
	output logic [SOC_W-1:0] soc
);

	logic              valid_s8, valid_s9, valid_s10, valid_s11;
	logic              hi_s8, hi_s9, hi_s10;
	logic              lo_s8, lo_s9, lo_s10;
	logic [SEG_W-1:0]  seg_s8, seg_s9, seg_s10;
	logic [DIFF_W-1:0] diff_s8;
	logic [SCALED_W-1:0] scaled_s9;
	logic [FRAC_W-1:0] frac_s10;
	logic [SOC_W-1:0]  soc_s11;

	logic [SEG_W-1:0]    seg_c;
	logic [MV_W-1:0]     diff_c;
	logic [SCALED_W-1:0] diff_ext;
	logic [PROD_W-1:0]   prod_c;
	logic [SOC_W-1:0]    soc_c;

	always_comb begin
		seg_c = '0;
		for (int i = 1; i < SEGMENTS; i++) begin
			if (avg_mv[MV_W-1:0] >= OCV_MV[i]) begin
				seg_c = SEG_W'(i);
			end
		end
		diff_c = avg_mv[MV_W-1:0] - OCV_MV[seg_c];
	end

	assign diff_ext = {{(SCALED_W-DIFF_W){1'b0}}, diff_s8};
	assign prod_c   = PROD_W'(scaled_s9) * PROD_W'(SEG_RECIP[seg_s9]);

	always_comb begin
		if (hi_s10) begin
			soc_c = SOC_FULL;
		end else if (lo_s10) begin
			soc_c = SOC_EMPTY;
		end else begin
			soc_c = OCV_SOC[seg_s10] + {{(SOC_W-FRAC_W){1'b0}}, frac_s10};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
		end else begin
			valid_s8  <= in_valid;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
		end
	end

	always_ff @(posedge clk) begin
		hi_s8     <= avg_mv > NUM_W'(OCV_MV[OCV_POINTS-1]);
		lo_s8     <= avg_mv < NUM_W'(OCV_MV[0]);
		seg_s8    <= seg_c;
		diff_s8   <= diff_c[DIFF_W-1:0];
		hi_s9     <= hi_s8;
		lo_s9     <= lo_s8;
		seg_s9    <= seg_s8;
		scaled_s9 <= (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
		hi_s10    <= hi_s9;
		lo_s10    <= lo_s9;
		seg_s10   <= seg_s9;
		frac_s10  <= prod_c[RECIP_SHIFT +: FRAC_W];
		soc_s11   <= soc_c;
	end

	assign out_valid = valid_s11;
	assign soc       = soc_s11;

endmodule

// ----- sv/ocv_soc_interpolator_top.sv -----
// Top level of the OCV state-of-charge lookup.
// Depends on ocvsoc_pkg, ocvsoc_div_stage and ocvsoc_interp.
//
// Takes one pack voltage item per clock and returns its state of charge in
// 0.1 % units, with done high for a single cycle per item; busy is never
// raised and the receiver cannot stall. Each item passes through the
// scale-by-100 stage, six divider stages of four quotient bits each (average
// cell mV = pack * 100 / cell_count), and four interpolation stages around
// the reciprocal multiplier. Write cell_count only while no item is in
// flight; a cell count of zero gives full charge.
module ocv_soc_interpolator_top import ocvsoc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [PACK_W-1:0] pack_voltage,
	input  logic              cell_count_we,
	input  logic [CELL_W-1:0] cell_count,
	output logic              done,
	output logic [SOC_W-1:0]  soc_permille
);

	logic [CELL_W-1:0] cell_count_q;
	logic              valid_s1;
	div_word_t         word_s1;
	logic [NUM_W-1:0]  pack_ext;

	logic      div_valid_s [DIV_STAGES+1];
	div_word_t div_word_s  [DIV_STAGES+1];

	assign busy     = 1'b0;
	assign pack_ext = {{(NUM_W-PACK_W){1'b0}}, pack_voltage};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= CELL_COUNT_RESET;
			valid_s1     <= 1'b0;
		end else begin
			if (cell_count_we) begin
				cell_count_q <= cell_count;
			end
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		word_s1.rem <= '0;
		word_s1.num <= (pack_ext << 6) + (pack_ext << 5) + (pack_ext << 2);
		word_s1.dvs <= cell_count_q;
	end

	assign div_valid_s[0] = valid_s1;
	assign div_word_s[0]  = word_s1;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		ocvsoc_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid_s[g]),
			.in_word   (div_word_s[g]),
			.out_valid (div_valid_s[g+1]),
			.out_word  (div_word_s[g+1])
		);
	end

	ocvsoc_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid_s[DIV_STAGES]),
		.avg_mv    (div_word_s[DIV_STAGES].num),
		.out_valid (done),
		.soc       (soc_permille)
	);

endmodule

// ----- sv/ocvsoc_checker.sv -----
// Port-level checks for the OCV state-of-charge lookup, bound to the top level.
// Depends on ocvsoc_pkg and ocv_soc_interpolator_top.
module ocvsoc_checker import ocvsoc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [PACK_W-1:0] pack_voltage,
	input logic              cell_count_we,
	input logic [CELL_W-1:0] cell_count,
	input logic              done,
	input logic [SOC_W-1:0]  soc_permille
);

	localparam int LATENCY = 11;

	a_item_returns: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted item gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without accepted item");

	a_soc_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> soc_permille <= SOC_FULL)
		else $error("state of charge out of range");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind ocv_soc_interpolator_top ocvsoc_checker u_checker (.*);
